// ----- hw/rtl/stb_pkg.sv -----
// Package for the soft timer bank: slot record, action codes, op and status structs.
// No dependencies; used by every module of the block.
package stb_pkg;

   localparam int NUM_TIMERS_DEF = 16;
   localparam int SLOT_W         = 4;
   localparam int TIME_W         = 32;
   localparam int ACTION_W       = 3;

   typedef enum logic [ACTION_W-1:0] {
      ACT_REGISTER = 3'd0,
      ACT_RELEASE  = 3'd1,
      ACT_START    = 3'd2,
      ACT_QUERY    = 3'd3,
      ACT_SCAN     = 3'd4
   } action_type;

   // one timer slot as it travels round the ring
   typedef struct packed {
      logic              in_use;
      logic              running;
      logic              expired;
      logic [TIME_W-1:0] stamp;
      logic [TIME_W-1:0] tmo;
   } entry_type;

   // item latched at accept, handed to the head unit
   typedef struct packed {
      action_type        action;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] now;
   } op_type;

   // what the head unit reports for the slot passing it this cycle
   typedef struct packed {
      logic claim;
      logic drop;
      logic flag;
   } head_stat_type;

endpackage

// ----- hw/rtl/stb_cell.sv -----
// One ring cell of the soft timer bank: holds one slot record, passes it on when shifting.
// Depends on stb_pkg.
module stb_cell
   import stb_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      shift,
   input  entry_type entry_i,
   output entry_type entry_o
);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = shift ? entry_i : entry_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry_o = entry_ff;

endmodule

// ----- hw/rtl/stb_head.sv -----
// Head unit of the soft timer bank: applies the current action to the slot at the ring head.
// Depends on stb_pkg.
module stb_head
   import stb_pkg::*;
#(
   parameter int IDX_W = 4
) (
   input  entry_type     entry_i,
   input  op_type        op_i,
   input  logic [IDX_W-1:0] step_i,
   input  logic          claimed_i,
   output entry_type     entry_o,
   output head_stat_type stat_o
);

   localparam int CMP_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

   logic              hit;
   logic [TIME_W-1:0] age;

   assign hit = (CMP_W'(step_i) == CMP_W'(op_i.slot));
   // wraps modulo 2^32
   assign age = op_i.now - entry_i.stamp;

   always_comb begin
      entry_o = entry_i;
      stat_o  = '0;
      case (op_i.action)
         ACT_REGISTER: begin
            if (!claimed_i && !entry_i.in_use) begin
               entry_o.in_use = 1'b1;
               stat_o.claim   = 1'b1;
            end
         end
         ACT_RELEASE: begin
            if (hit) begin
               stat_o.drop = entry_i.in_use;
               entry_o     = '0;
            end
         end
         ACT_START: begin
            if (hit) begin
               entry_o.stamp   = op_i.now;
               entry_o.tmo     = op_i.period;
               entry_o.running = 1'b1;
               entry_o.expired = 1'b0;
            end
         end
         ACT_QUERY: begin
            if (hit) begin
               stat_o.flag = entry_i.expired;
            end
         end
         ACT_SCAN: begin
            if (entry_i.in_use && entry_i.running && (age > entry_i.tmo)) begin
               entry_o.expired = 1'b1;
               entry_o.running = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- hw/rtl/soft_timer_bank_unit.sv -----
// Soft timer bank top level: ring of slot cells, head unit, sequencing and result register.
// Depends on stb_pkg, stb_cell and stb_head.
//
//  channel | ports                                       | handshake
//  --------+---------------------------------------------+---------------------------
//  request | req_action req_slot req_period req_now      | start high, busy low
//  result  | rsp_slot_given rsp_success rsp_elapsed_flag | rsp_valid, one cycle only
//
// Every item is taken at the accept edge, then the ring shifts round once, one slot
// passing the head unit per shift. The result strobe is registered on the last
// shift and shows in the cycle after it.
// busy drops in the strobe cycle, so the next item can be accepted there.
// Synchronous reset clears every slot, the slot count and the sequencer at once.
// The receiver cannot stall: the result is shown for one cycle and then gone.
module soft_timer_bank_unit
   import stb_pkg::*;
#(
   parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [TIME_W-1:0]   req_period,
   input  logic [TIME_W-1:0]   req_now,
   output logic                rsp_valid,
   output logic [SLOT_W-1:0]   rsp_slot_given,
   output logic                rsp_success,
   output logic                rsp_elapsed_flag
);

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W = $clog2(NUM_TIMERS + 1);

   // sequencer and item registers
   logic              busy_ff, busy_in;
   logic [IDX_W-1:0]  step_ff, step_in;
   op_type            op_ff, op_in;
   logic              slot_ok_ff, slot_ok_in;
   logic              found_ff, found_in;
   logic [SLOT_W-1:0] given_ff, given_in;
   logic              flag_ff, flag_in;
   logic [CNT_W-1:0]  used_count_ff, used_count_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] rsp_given_ff, rsp_given_in;
   logic              rsp_success_ff, rsp_success_in;
   logic              rsp_flag_ff, rsp_flag_in;

   logic              accept;
   logic              last_step;
   entry_type         ring [NUM_TIMERS];
   entry_type         head_out;
   head_stat_type     stat;

   assign accept    = start && !busy_ff;
   assign last_step = (step_ff == IDX_W'(NUM_TIMERS - 1));

   // ring: cell k takes from cell k+1, the last cell takes the head's rewritten record
   for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_ring
      entry_type feed;
      if (k == NUM_TIMERS - 1) begin : g_tail
         assign feed = head_out;
      end else begin : g_mid
         assign feed = ring[k+1];
      end
      stb_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .shift   (busy_ff),
         .entry_i (feed),
         .entry_o (ring[k])
      );
   end

   // cell 0 holds slot step_ff while busy
   stb_head #(
      .IDX_W (IDX_W)
   ) u_head (
      .entry_i   (ring[0]),
      .op_i      (op_ff),
      .step_i    (step_ff),
      .claimed_i (found_ff),
      .entry_o   (head_out),
      .stat_o    (stat)
   );

   // sequencing and per-item bookkeeping
   always_comb begin
      busy_in       = busy_ff;
      step_in       = step_ff;
      op_in         = op_ff;
      slot_ok_in    = slot_ok_ff;
      found_in      = found_ff;
      given_in      = given_ff;
      flag_in       = flag_ff;
      used_count_in = used_count_ff;
      if (accept) begin
         busy_in       = 1'b1;
         step_in       = '0;
         op_in.action  = action_type'(req_action);
         op_in.slot    = req_slot;
         op_in.period  = req_period;
         op_in.now     = req_now;
         slot_ok_in    = (32'(req_slot) < 32'(NUM_TIMERS));
         found_in      = 1'b0;
         given_in      = '0;
         flag_in       = 1'b0;
      end else if (busy_ff) begin
         step_in = last_step ? '0 : step_ff + 1'b1;
         busy_in = !last_step;
         if (stat.claim) begin
            found_in      = 1'b1;
            given_in      = SLOT_W'(step_ff);
            used_count_in = used_count_ff + 1'b1;
         end
         if (stat.drop && (used_count_ff != '0)) begin
            used_count_in = used_count_ff - 1'b1;
         end
         if (stat.flag) begin
            flag_in = 1'b1;
         end
      end
   end

   // result formed on the last shift, including what the head saw in that cycle
   always_comb begin
      rsp_valid_in   = busy_ff && last_step;
      rsp_given_in   = '0;
      rsp_success_in = 1'b0;
      rsp_flag_in    = 1'b0;
      case (op_ff.action)
         ACT_REGISTER: begin
            rsp_success_in = found_ff || stat.claim;
            rsp_given_in   = stat.claim ? SLOT_W'(step_ff) : given_ff;
         end
         ACT_RELEASE, ACT_START: begin
            rsp_success_in = slot_ok_ff;
         end
         ACT_QUERY: begin
            rsp_success_in = slot_ok_ff;
            rsp_flag_in    = flag_ff || stat.flag;
         end
         ACT_SCAN: begin
            rsp_success_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         step_ff       <= '0;
         found_ff      <= 1'b0;
         used_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         step_ff       <= step_in;
         found_ff      <= found_in;
         used_count_ff <= used_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      slot_ok_ff     <= slot_ok_in;
      given_ff       <= given_in;
      flag_ff        <= flag_in;
      rsp_given_ff   <= rsp_given_in;
      rsp_success_ff <= rsp_success_in;
      rsp_flag_ff    <= rsp_flag_in;
   end

   assign busy             = busy_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot_given   = rsp_valid_ff ? rsp_given_ff : '0;
   assign rsp_success      = rsp_valid_ff ? rsp_success_ff : 1'b0;
   assign rsp_elapsed_flag = rsp_valid_ff ? rsp_flag_ff : 1'b0;

`ifndef ASSERT_OFF
   a_rsp_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $fell(busy_ff))
      else $error("result strobe without end of ring pass");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      used_count_ff <= CNT_W'(NUM_TIMERS))
      else $error("slot count above bank size");

   a_idle_step: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (step_ff == '0))
      else $error("ring position not home while idle");

   a_found_reg: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && found_ff) |-> (op_ff.action == ACT_REGISTER))
      else $error("claim seen outside a register item");
`endif

endmodule

// ----- tb/tb_soft_timer_bank_unit.sv -----
// Self-checking testbench for soft_timer_bank_unit: directed and random timer-bank items.
// Depends on stb_pkg and the soft_timer_bank_unit RTL; needs nothing else to run.
`timescale 1ns / 100ps

module tb_soft_timer_bank_unit;
   import stb_pkg::*;

   localparam int NUM_TIMERS = NUM_TIMERS_DEF;

   // action codes outside the package enum, all of which must be ignored
   localparam logic [ACTION_W-1:0] ACT_UNDEF_FIRST = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_UNDEF_MID   = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_UNDEF_LAST  = 3'd7;

   // drain wait after the last result, longer than one item takes
   localparam int DRAIN_CYCLES = NUM_TIMERS + 4;
   localparam int DRAIN_LIMIT  = 1000;
   // roughly 610 items in all; the limit is set many times higher than they need
   localparam int RUN_LIMIT_NS = 5_000_000;

   typedef struct packed {
      logic [SLOT_W-1:0] slot_given;
      logic              success;
      logic              elapsed_flag;
   } timer_rsp_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [ACTION_W-1:0] req_action;
   logic [SLOT_W-1:0]   req_slot;
   logic [TIME_W-1:0]   req_period;
   logic [TIME_W-1:0]   req_now;
   logic                rsp_valid;
   logic [SLOT_W-1:0]   rsp_slot_given;
   logic                rsp_success;
   logic                rsp_elapsed_flag;

   // shadow of the timer bank, updated as each item is accepted
   logic              t_alloc [NUM_TIMERS];
   logic              t_run   [NUM_TIMERS];
   logic              t_done  [NUM_TIMERS];
   logic [TIME_W-1:0] t_stamp [NUM_TIMERS];
   logic [TIME_W-1:0] t_limit [NUM_TIMERS];
   int unsigned       alloc_count;

   timer_rsp_type expected_rsp_q[$];

   int error_count;
   int items_sent;
   int results_checked;
   int expiry_count;
   int full_count;

   // sender pacing: bursts of back-to-back items separated by idle gaps
   bit idle_on;
   int burst_left;

   soft_timer_bank_unit #(
      .NUM_TIMERS(NUM_TIMERS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_slot        (req_slot),
      .req_period      (req_period),
      .req_now         (req_now),
      .rsp_valid       (rsp_valid),
      .rsp_slot_given  (rsp_slot_given),
      .rsp_success     (rsp_success),
      .rsp_elapsed_flag(rsp_elapsed_flag)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("%0t: run time limit reached", $time);
      $display("soft_timer_bank_unit verification failed");
      $finish;
   end

   // ---------------------------------------------------------------
   // Bank predictor: applies one item to the shadow and returns the
   // result the block should give for it.
   // ---------------------------------------------------------------
   function automatic void wipe_timer(int idx);
      t_alloc[idx] = 1'b0;
      t_run[idx]   = 1'b0;
      t_done[idx]  = 1'b0;
      t_stamp[idx] = '0;
      t_limit[idx] = '0;
   endfunction

   function automatic timer_rsp_type predict_timer_op(logic [ACTION_W-1:0] act,
                                                      logic [SLOT_W-1:0] slot,
                                                      logic [TIME_W-1:0] period,
                                                      logic [TIME_W-1:0] now);
      timer_rsp_type     r;
      bit                found;
      bit                slot_ok;
      logic [TIME_W-1:0] since;
      r       = '0;
      found   = 1'b0;
      slot_ok = (int'(slot) < NUM_TIMERS);
      case (act)
         ACT_REGISTER: begin
            // lowest free slot wins; none free means failure
            for (int i = 0; i < NUM_TIMERS; i++) begin
               if (!found && !t_alloc[i]) begin
                  t_alloc[i]   = 1'b1;
                  alloc_count++;
                  r.slot_given = i[SLOT_W-1:0];
                  r.success    = 1'b1;
                  found        = 1'b1;
               end
            end
            if (!found) full_count++;
         end
         ACT_RELEASE: begin
            if (slot_ok) begin
               // count only drops for a slot that was really held
               if (t_alloc[slot] && alloc_count > 0) alloc_count--;
               wipe_timer(int'(slot));
               r.success = 1'b1;
            end
         end
         ACT_START: begin
            if (slot_ok) begin
               t_stamp[slot] = now;
               t_limit[slot] = period;
               t_run[slot]   = 1'b1;
               t_done[slot]  = 1'b0;
               r.success     = 1'b1;
            end
         end
         ACT_QUERY: begin
            if (slot_ok) begin
               r.elapsed_flag = t_done[slot];
               r.success      = 1'b1;
            end
         end
         ACT_SCAN: begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
               since = now - t_stamp[i];   // wraps modulo 2^32
               if (t_alloc[i] && t_run[i] && since > t_limit[i]) begin
                  t_done[i] = 1'b1;
                  t_run[i]  = 1'b0;
                  expiry_count++;
               end
            end
            r.success = 1'b1;
         end
         default: ;   // undefined actions leave everything alone
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Sender: one item per call. Fields change on the falling edge;
   // the item is taken at the first rising edge with busy low.
   // start is left high on return so back-to-back items need no drop.
   // ---------------------------------------------------------------
   task automatic send_timer_item(logic [ACTION_W-1:0] act, logic [SLOT_W-1:0] slot,
                                  logic [TIME_W-1:0] period, logic [TIME_W-1:0] now);
      int gap;
      gap = 0;
      if (idle_on && burst_left == 0) begin
         gap        = $urandom_range(1, 20);
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start      <= 1'b1;
      req_action <= act;
      req_slot   <= slot;
      req_period <= period;
      req_now    <= now;
      // busy is a registered output, so its pre-edge value is read here
      do @(posedge clock); while (busy);
      expected_rsp_q.push_back(predict_timer_op(act, slot, period, now));
      items_sent++;
   endtask

   // ---------------------------------------------------------------
   // Result checker: every strobe is matched against the oldest
   // expectation. The strobe lasts one cycle and cannot be held off.
   // ---------------------------------------------------------------
   always @(posedge clock) begin : check_rsp
      timer_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsp_q.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result slot_given=%0d success=%0b elapsed_flag=%0b",
                     $time, rsp_slot_given, rsp_success, rsp_elapsed_flag);
         end else begin
            want = expected_rsp_q.pop_front();
            results_checked++;
            if (rsp_slot_given !== want.slot_given) begin
               error_count++;
               $display("%0t: slot_given expected %0d actual %0d",
                        $time, want.slot_given, rsp_slot_given);
            end
            if (rsp_success !== want.success) begin
               error_count++;
               $display("%0t: success expected %0b actual %0b",
                        $time, want.success, rsp_success);
            end
            if (rsp_elapsed_flag !== want.elapsed_flag) begin
               error_count++;
               $display("%0t: elapsed_flag expected %0b actual %0b",
                        $time, want.elapsed_flag, rsp_elapsed_flag);
            end
         end
      end
   end

   // random slot, usually one that is currently held
   function automatic logic [SLOT_W-1:0] pick_slot();
      logic [SLOT_W-1:0] s;
      s = SLOT_W'($urandom_range(0, NUM_TIMERS - 1));
      if ($urandom_range(0, 99) < 85) begin
         for (int k = 0; k < 32 && !t_alloc[s]; k++)
            s = SLOT_W'($urandom_range(0, NUM_TIMERS - 1));
      end
      return s;
   endfunction

   // ---------------------------------------------------------------
   // Test tasks
   // ---------------------------------------------------------------

   // claim every slot, then one more to hit the full bank; free slot 5
   task automatic test_fill_bank();
      for (int i = 0; i <= NUM_TIMERS; i++)
         send_timer_item(ACT_REGISTER, SLOT_W'($urandom), $urandom, $urandom);
      send_timer_item(ACT_RELEASE, 4'd5, '0, '0);
   endtask

   // expiry is strictly greater-than, measured across the tick wrap
   task automatic test_expiry_edges();
      send_timer_item(ACT_START, 4'd0, 32'h0000_0010, 32'hFFFF_FFF0);
      send_timer_item(ACT_SCAN,  4'd0, '0, 32'h0000_0000);   // diff equals period
      send_timer_item(ACT_SCAN,  4'd0, '0, 32'h0000_0001);   // one past: expires
      send_timer_item(ACT_QUERY, 4'd0, '0, '0);
      send_timer_item(ACT_START, 4'd15, 32'hFFFF_FFFF, 32'h0000_0000);
      send_timer_item(ACT_SCAN,  4'd15, '1, 32'hFFFF_FFFF);  // longest period never ends
      send_timer_item(ACT_QUERY, 4'd15, '0, '1);
   endtask

   // start, scan, query and release on a slot nobody holds
   task automatic test_free_slot_cases();
      send_timer_item(ACT_START,   4'd5, 32'h0, 32'h0000_0100);
      send_timer_item(ACT_SCAN,    4'd5, '0, 32'h0000_0200);
      send_timer_item(ACT_QUERY,   4'd5, '0, '0);
      send_timer_item(ACT_RELEASE, 4'd5, '0, '0);
   endtask

   task automatic test_unknown_actions();
      send_timer_item(ACT_UNDEF_FIRST, 4'd15, '1, '1);
      send_timer_item(ACT_UNDEF_MID,   4'd3,  '1, '0);
      send_timer_item(ACT_UNDEF_LAST,  4'd0,  '0, '0);
   endtask

   // mostly well-formed traffic: claim, arm, scan with time moving on, poll, free
   task automatic test_random_traffic(int count);
      logic [TIME_W-1:0]   tick;
      logic [TIME_W-1:0]   period;
      logic [ACTION_W-1:0] act;
      int                  roll;
      tick = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255) : $urandom;
      for (int n = 0; n < count; n++) begin
         // alternate paced and back-to-back stretches
         if (n % 90 == 0) idle_on = ($urandom_range(0, 3) != 0);
         tick += $urandom_range(0, 10);
         if ($urandom_range(0, 49) == 0) tick = $urandom;
         case ($urandom_range(0, 9))
            0:       period = '0;
            1:       period = '1;
            2:       period = $urandom;
            default: period = $urandom_range(1, 60);
         endcase
         roll = $urandom_range(0, 99);
         if      (roll < 14) act = ACT_REGISTER;
         else if (roll < 24) act = ACT_RELEASE;
         else if (roll < 48) act = ACT_START;
         else if (roll < 68) act = ACT_QUERY;
         else if (roll < 94) act = ACT_SCAN;
         else                act = ACTION_W'($urandom_range(0, 7));   // noise
         send_timer_item(act, pick_slot(), period, tick);
      end
   endtask

   // wholly random fields, including undefined actions and wild times
   task automatic test_random_noise(int count);
      idle_on = 1'b1;
      for (int n = 0; n < count; n++)
         send_timer_item(ACTION_W'($urandom_range(0, 7)), SLOT_W'($urandom),
                         $urandom, $urandom);
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin : main
      int waited;
      start       = 1'b0;
      req_action  = ACT_REGISTER;
      req_slot    = '0;
      req_period  = '0;
      req_now     = '0;
      reset       = 1'b1;
      error_count = 0;
      items_sent  = 0;
      results_checked = 0;
      expiry_count    = 0;
      full_count      = 0;
      alloc_count     = 0;
      idle_on    = 1'b1;
      burst_left = 0;
      for (int i = 0; i < NUM_TIMERS; i++) wipe_timer(i);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_fill_bank();
      test_expiry_edges();
      test_free_slot_cases();
      test_unknown_actions();
      test_random_traffic(520);
      test_random_noise(60);

      @(negedge clock);
      start <= 1'b0;

      waited = 0;
      while (expected_rsp_q.size() > 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_rsp_q.size() > 0) begin
         $display("%0t: %0d results never arrived", $time, expected_rsp_q.size());
         $display("soft_timer_bank_unit verification failed");
         $finish;
      end else begin
         repeat (DRAIN_CYCLES) @(posedge clock);
         $display("Run: %0d items sent, %0d results compared, %0d mismatches.",
                  items_sent, results_checked, error_count);
         $display("Seen: %0d timer expiries, %0d claims refused on a full bank.",
                  expiry_count, full_count);
         if (error_count == 0)
            $display("soft_timer_bank_unit verification clean");
         else
            $display("soft_timer_bank_unit verification failed");
         $finish;
      end
   end

endmodule
